### hw/rtl/lrma_pkg.sv
// ----------------------------------------------------------------------------
// lrma_pkg: shared constants for the load resistance measurement block
// Widths, limits and reset values used by the measurement datapath.
// ----------------------------------------------------------------------------
package lrma_pkg;

  localparam int unsigned AdcW     = 12;
  localparam int unsigned ScaleW   = 10;
  localparam int unsigned LoadW    = 8;
  localparam int unsigned IdxW     = 3;
  localparam int unsigned ProdW    = AdcW + ScaleW;
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 24;

  localparam logic [AdcW-1:0]   AdcFullScale = 12'd4095;
  localparam logic [LoadW-1:0]  LoadMax      = 8'd255;
  localparam logic [LoadW-1:0]  AverageReset = 8'd30;
  localparam logic [ScaleW-1:0] ScaleReset   = 10'd510;
  localparam logic [IdxW-1:0]   RunLength    = 3'd6;
  localparam logic [IdxW-1:0]   FirstKept    = 3'd2;

endpackage

### hw/rtl/load_resistance_measure_average.sv
// ----------------------------------------------------------------------------
// load_resistance_measure_average: load resistance sampling with averaging
// Per tick: detect-edge run control, load = scale*adc/(4095-adc) saturated
// at 255 via a serial restoring divider, and the average of samples 2..5.
// ----------------------------------------------------------------------------
// Sequence: a measuring tick steps through accept, multiply, saturation check,
//   8 divider steps and finish; a saturating ratio leaves the divider state
//   without dividing, and a tick that takes no measurement goes from accept
//   straight to finish.
// Flow: tready stays low until the finish step, so the block takes no new tick
//   until it is through with the last; the serial divider (one quotient bit per
//   cycle) sets the longest path. A waiting result does not block the next
//   input beat; it only holds the finish step until the output frees.
// Reset: rst_ni async, active low; clears control state, scale to 510,
//   average to 30. No clearing pass; the kept-sample file has no reset.
// ----------------------------------------------------------------------------
module load_resistance_measure_average
  import lrma_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // config: scale_resistance
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [ScaleW-1:0]   cfg_data_i,
  // input tick stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [0] detect_level, [1] pwm_active, [2] mic_active, [14:3] adc_sample
  input  logic [InDataW-1:0]  s_axis_tdata,
  // result stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [0] measuring, [8:1] sample_load, [9] zero_load, [17:10] average_load
  output logic [OutDataW-1:0] m_axis_tdata,
  output logic                m_axis_tlast   // done_res
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_CMP,
    ST_DIV,
    ST_FIN
  } state_e;

  state_e            state_q;
  logic [ScaleW-1:0] scale_q;

  // tick control state
  logic              prev_detect_q;
  logic              run_q;
  logic [IdxW-1:0]   idx_q;
  logic              zero_q;
  logic [LoadW-1:0]  avg_q;
  logic [LoadW-1:0]  kept_q [4];

  // divider datapath
  logic [AdcW-1:0]   adc_q;
  logic [AdcW-1:0]   div_q;      // 4095 - adc
  logic [ProdW-1:0]  prod_q;
  logic              sat_q;
  logic [AdcW-1:0]   rem_q;
  logic [LoadW-1:0]  quo_q;
  logic [2:0]        bit_q;      // current product bit fed into remainder

  // output register
  logic              out_valid_q;
  logic [OutDataW-1:0] out_data_q;
  logic              out_last_q;

  // input field views
  logic            in_detect, in_pwm, in_mic;
  logic [AdcW-1:0] in_adc;
  assign in_detect = s_axis_tdata[0];
  assign in_pwm    = s_axis_tdata[1];
  assign in_mic    = s_axis_tdata[2];
  assign in_adc    = s_axis_tdata[14:3];

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  // run control seen on the accepted beat
  logic track, restart;
  assign track   = in_pwm && !in_mic;
  assign restart = track && (prev_detect_q != in_detect);

  // one restoring divider step; the low product bits shift in one per step
  logic [LoadW-1:0] prod_lo;
  logic [AdcW:0]    trial;
  logic             trial_ge;
  assign prod_lo  = prod_q[LoadW-1:0];
  assign trial    = {rem_q, prod_lo[bit_q]};
  assign trial_ge = (trial >= {1'b0, div_q});

  // finish-step values
  logic [LoadW-1:0] load;
  logic [IdxW-1:0]  idx_inc;
  logic             keep, finish_run;
  logic [LoadW+1:0] sum;
  logic             out_free;
  logic             fin_fire;

  always_comb begin
    load       = sat_q ? LoadMax : quo_q;
    idx_inc    = idx_q + 3'd1;
    keep       = (idx_q >= FirstKept) && (idx_q < RunLength);
    finish_run = (idx_inc >= RunLength);
    // the sample that closes the run lands in the last slot
    sum        = {2'b00, kept_q[0]} + {2'b00, kept_q[1]} +
                 {2'b00, kept_q[2]} + {2'b00, load};
    out_free   = !out_valid_q || m_axis_tready;
    fin_fire   = (state_q == ST_FIN) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      scale_q       <= ScaleReset;
      prev_detect_q <= 1'b0;
      run_q         <= 1'b0;
      idx_q         <= '0;
      zero_q        <= 1'b0;
      avg_q         <= AverageReset;
      out_valid_q   <= 1'b0;
      out_last_q    <= 1'b0;
      out_data_q    <= '0;
      bit_q         <= '0;
      adc_q         <= '0;
      div_q         <= '0;
      prod_q        <= '0;
      sat_q         <= 1'b0;
      rem_q         <= '0;
      quo_q         <= '0;
    end else begin
      if (cfg_valid_i) begin
        scale_q <= cfg_data_i;
      end
      // a finishing tick reloads the output register in the same cycle
      if (out_valid_q && m_axis_tready && !fin_fire) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            adc_q <= in_adc;
            div_q <= AdcFullScale - in_adc;
            if (track) begin
              prev_detect_q <= in_detect;
            end
            if (restart) begin
              run_q <= 1'b1;
              idx_q <= '0;
            end
            state_q <= (restart || run_q) ? ST_MUL : ST_FIN;
          end
        end
        ST_MUL: begin
          prod_q  <= ProdW'({12'd0, scale_q} * {10'd0, adc_q});
          state_q <= ST_CMP;
        end
        ST_CMP: begin
          // quotient > 255 iff prod/256 >= divisor; full scale has divisor 0
          sat_q   <= (adc_q == AdcFullScale) ||
                     (prod_q[ProdW-1:LoadW] >= {2'b00, div_q});
          rem_q   <= prod_q[AdcW+LoadW-1:LoadW];
          quo_q   <= '0;
          bit_q   <= 3'd7;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          if (sat_q) begin
            state_q <= ST_FIN;
          end else begin
            rem_q <= trial_ge ? AdcW'(trial - {1'b0, div_q}) : trial[AdcW-1:0];
            quo_q <= {quo_q[LoadW-2:0], trial_ge};
            bit_q <= bit_q - 3'd1;
            if (bit_q == 3'd0) begin
              state_q <= ST_FIN;
            end
          end
        end
        ST_FIN: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
            if (run_q) begin
              zero_q <= (load == '0);
              if (keep) begin
                kept_q[2'(idx_q - FirstKept)] <= load;
              end
              idx_q <= idx_inc;
              if (finish_run) begin
                avg_q      <= sum[LoadW+1:2];
                run_q      <= 1'b0;
                out_last_q <= 1'b1;
                out_data_q <= {6'd0, sum[LoadW+1:2], (load == '0), load, 1'b1};
              end else begin
                out_last_q <= 1'b0;
                out_data_q <= {6'd0, avg_q, (load == '0), load, 1'b1};
              end
            end else begin
              out_last_q <= 1'b0;
              out_data_q <= {6'd0, avg_q, zero_q, 8'd0, 1'b0};
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // a completed run is always a measuring beat
  a_done_measures: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[0])
    else $error("done without measurement");

  // no load value reported on a non-measuring tick
  a_idle_load_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[8:1] == 8'd0)
    else $error("load reported while not measuring");

  // an active run never sits at or past its end index
  a_run_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q |-> idx_q < RunLength)
    else $error("run index out of range");
`endif

endmodule

### sim/tb_load_resistance_measure_average.sv
// ----------------------------------------------------------------------------
// tb_load_resistance_measure_average: self-checking bench for the load meter
// Streams detect/PWM/mic/ADC ticks into the block, predicts every result beat
// in lockstep and compares it field by field. Reprograms the scale register
// between drained phases, with random gaps and stalls on both streams.
// ----------------------------------------------------------------------------
module tb_load_resistance_measure_average;
  import lrma_pkg::*;

  localparam int unsigned ClkHalf       = 10;
  localparam int unsigned TimeoutCycles = 400000;
  localparam int unsigned SegItems      = 44;  // random ticks per idle mode
  localparam int unsigned SettleCycles  = 16;  // covers the longest tick through the block

  // One tick, detect_level in the lowest bit.
  typedef struct packed {
    logic [AdcW-1:0] adc;
    logic            mic;
    logic            pwm;
    logic            detect;
  } tick_t;

  typedef struct packed {
    logic             measuring;
    logic [LoadW-1:0] sample_load;
    logic             zero_load;
    logic [LoadW-1:0] average_load;
    logic             done;
  } meas_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [ScaleW-1:0]   cfg_data_i    = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // [0] detect_level, [1] pwm_active, [2] mic_active, [14:3] adc_sample
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // [0] measuring, [8:1] sample_load, [9] zero_load, [17:10] average_load
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tlast;   // done_res

  load_resistance_measure_average dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #ClkHalf clk_i = 1'b1;
    #ClkHalf clk_i = 1'b0;
  end

  // Hard stop in case a beat never shows up.
  initial begin
    #(TimeoutCycles * 2 * ClkHalf);
    $display("Verification failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Shadow of the meter state, advanced once per accepted tick beat.
  // --------------------------------------------------------------------------
  logic              prev_det  = 1'b0;
  logic              run_on    = 1'b0;
  logic [IdxW-1:0]   samp_idx  = '0;
  logic [LoadW-1:0]  kept [4]  = '{default: '0};
  logic [LoadW-1:0]  avg_val   = AverageReset;
  logic              zero_flg  = 1'b0;
  logic [ScaleW-1:0] scale_val = ScaleReset;

  tick_t tick_q  [$];   // ticks waiting to be sent
  meas_t meas_q  [$];   // predicted result beats, oldest first
  tick_t drv_tick;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned fail_cnt       = 0;
  logic        gen_prev       = 1'b0;  // detect level as the generator tracks it

  function automatic meas_t measure_tick(input tick_t t);
    meas_t       r;
    int unsigned prod, quo, sum;
    r = '0;
    // detect is only tracked while PWM runs and the mic is quiet
    if (t.pwm && !t.mic) begin
      if (prev_det != t.detect) begin
        run_on   = 1'b1;
        samp_idx = '0;
      end
      prev_det = t.detect;
    end
    if (run_on) begin
      r.measuring = 1'b1;
      if (t.adc == AdcFullScale) begin
        r.sample_load = LoadMax;  // no divide at full scale
      end else begin
        prod = int'(scale_val) * int'(t.adc);
        quo  = prod / (int'(AdcFullScale) - int'(t.adc));
        r.sample_load = (quo > LoadMax) ? LoadMax : LoadW'(quo);
      end
      zero_flg = (r.sample_load == '0);
      if (samp_idx >= FirstKept) kept[2'(samp_idx - FirstKept)] = r.sample_load;
      samp_idx = samp_idx + 1'b1;
      if (samp_idx == RunLength) begin
        sum     = kept[0] + kept[1] + kept[2] + kept[3];
        avg_val = LoadW'(sum >> 2);
        run_on  = 1'b0;
        r.done  = 1'b1;
      end
    end
    r.zero_load    = zero_flg;
    r.average_load = avg_val;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Tick driver: predicts on every accepted beat, then offers the next one.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) meas_q.push_back(measure_tick(drv_tick));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tick_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          drv_tick = tick_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= InDataW'(drv_tick);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: every beat must match the oldest prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : mon
    meas_t got, want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.measuring    = m_axis_tdata[0];
        got.sample_load  = m_axis_tdata[8:1];
        got.zero_load    = m_axis_tdata[9];
        got.average_load = m_axis_tdata[17:10];
        got.done         = m_axis_tlast;
        if (meas_q.size() == 0) begin
          $error("result beat with nothing expected: data %h last %b",
                 m_axis_tdata, m_axis_tlast);
          fail_cnt++;
        end else begin
          want = meas_q.pop_front();
          if (got.measuring !== want.measuring) begin
            $error("measuring: expected %0d, got %0d", want.measuring, got.measuring);
            fail_cnt++;
          end
          if (got.sample_load !== want.sample_load) begin
            $error("sample_load: expected %0d, got %0d",
                   want.sample_load, got.sample_load);
            fail_cnt++;
          end
          if (got.zero_load !== want.zero_load) begin
            $error("zero_load: expected %0d, got %0d", want.zero_load, got.zero_load);
            fail_cnt++;
          end
          if (got.average_load !== want.average_load) begin
            $error("average_load: expected %0d, got %0d",
                   want.average_load, got.average_load);
            fail_cnt++;
          end
          if (got.done !== want.done) begin
            $error("done_res: expected %0d, got %0d", want.done, got.done);
            fail_cnt++;
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic push_tick(input logic det, input logic pwm, input logic mic,
                           input logic [AdcW-1:0] adc);
    tick_t t;
    t = '{adc: adc, mic: mic, pwm: pwm, detect: det};
    tick_q.push_back(t);
    if (pwm && !mic) gen_prev = det;
  endtask

  // ADC values weighted toward the region where the ratio does not saturate.
  function automatic logic [AdcW-1:0] pick_adc();
    case ($urandom_range(0, 6))
      0:       return AdcW'($urandom_range(0, 4095));
      1:       return AdcW'($urandom_range(0, 64));
      2:       return AdcW'($urandom_range(0, 1500));
      3:       return AdcW'($urandom_range(4000, 4095));
      4:       return $urandom_range(0, 1) ? AdcFullScale : '0;
      default: return AdcW'($urandom_range(0, 400));
    endcase
  endfunction

  // A tick that does not restart a run.
  task automatic push_quiet();
    case ($urandom_range(0, 3))
      0, 1:    push_tick(gen_prev, 1'b1, 1'b0, pick_adc());
      2:       push_tick(1'($urandom_range(0, 1)), 1'b0, 1'($urandom_range(0, 1)),
                         pick_adc());
      default: push_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b1,
                         pick_adc());
    endcase
  endtask

  // Mostly complete six-sample runs, some restarted, some cut short,
  // plus plain noise ticks.
  task automatic push_random(input int unsigned n_items);
    int unsigned base, len;
    base = tick_q.size();
    while (tick_q.size() - base < n_items) begin
      if ($urandom_range(0, 9) < 7) begin
        push_tick(~gen_prev, 1'b1, 1'b0, pick_adc());
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 9) : 5;
        repeat (len) begin
          if ($urandom_range(0, 19) == 0) push_tick(~gen_prev, 1'b1, 1'b0, pick_adc());
          else push_quiet();
        end
      end else begin
        repeat ($urandom_range(1, 4))
          push_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)), AdcW'($urandom_range(0, 4095)));
      end
    end
  endtask

  // Block until all ticks are sent and all results are back, then settle.
  task automatic wait_drained();
    while (tick_q.size() > 0 || s_axis_tvalid || meas_q.size() > 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_scale(input logic [ScaleW-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    scale_val = val;
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : seq
    logic [ScaleW-1:0] scales [5];
    int unsigned       idle_mode [4][2];
    scales    = '{ScaleReset, 10'd0, 10'd1023, 10'd1, ScaleW'($urandom_range(2, 1022))};
    idle_mode = '{'{0, 0}, '{54, 0}, '{0, 54}, '{27, 27}};

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed ticks at reset scale.
    push_tick(1'b1, 1'b0, 1'b0, 12'd100);   // PWM off: detect change ignored
    push_tick(1'b1, 1'b1, 1'b1, 12'd200);   // mic active: ignored
    push_tick(1'b0, 1'b1, 1'b0, 12'd300);   // no change
    push_tick(1'b1, 1'b1, 1'b0, 12'd0);     // run starts, zero load
    push_tick(1'b1, 1'b1, 1'b0, 12'd4095);  // full scale
    push_tick(1'b0, 1'b0, 1'b0, 12'd4094);  // detect flips with PWM off, ratio saturates
    push_tick(1'b1, 1'b0, 1'b1, 12'd1);
    push_tick(1'b1, 1'b1, 1'b0, 12'd2000);
    push_tick(1'b1, 1'b1, 1'b0, 12'd12);    // sixth sample: average stored
    push_tick(1'b1, 1'b1, 1'b0, 12'd500);   // idle after run
    push_tick(1'b0, 1'b1, 1'b0, 12'd3000);  // new run
    push_tick(1'b0, 1'b1, 1'b0, 12'd64);
    push_tick(1'b0, 1'b1, 1'b0, 12'd777);
    push_tick(1'b1, 1'b1, 1'b0, 12'd4095);  // restart mid-run
    push_tick(1'b1, 1'b1, 1'b0, 12'd4095);
    push_tick(1'b1, 1'b1, 1'b0, 12'd2048);
    push_tick(1'b1, 1'b1, 1'b0, 12'd1365);
    push_tick(1'b1, 1'b1, 1'b0, 12'd1366);
    push_tick(1'b1, 1'b1, 1'b0, 12'd0);
    push_tick(1'b0, 1'b1, 1'b0, 12'd4095);  // run of mostly saturated loads
    push_tick(1'b0, 1'b1, 1'b0, 12'd4094);
    push_tick(1'b0, 1'b1, 1'b0, 12'd4093);
    push_tick(1'b0, 1'b1, 1'b0, 12'd3);
    push_tick(1'b0, 1'b1, 1'b0, 12'd4095);
    push_tick(1'b0, 1'b1, 1'b0, 12'd4095);

    // Each scale setting runs through every idle mode; the block is drained
    // before each register write.
    foreach (scales[p]) begin
      if (p > 0) write_scale(scales[p]);
      foreach (idle_mode[m]) begin
        send_idle_pct  = idle_mode[m][0];
        recv_stall_pct = idle_mode[m][1];
        push_random(SegItems);
        while (tick_q.size() > 0) @(posedge clk_i);
      end
      wait_drained();
    end

    if (fail_cnt == 0 && meas_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/lrma_pkg.sv
hw/rtl/load_resistance_measure_average.sv
sim/tb_load_resistance_measure_average.sv
